// File: rtl/rope_pkg.sv
// rope_pkg: shared types, constants and the theta table builder for the rotary
// position embedding block. No dependencies; every file but rope_if imports it.

package rope_pkg;

   // head geometry, fixed at build time
   localparam int unsigned HEAD_SIZE = 128;
   localparam longint unsigned DIM_EFF = (HEAD_SIZE < 2) ? 64'd2 : 64'(HEAD_SIZE);
   localparam longint unsigned PAIRS = DIM_EFF / 64'd2;

   localparam int THETA_ENTRIES = 64;
   localparam int CORDIC_STAGES = 16;

   // fixed-point constants
   localparam longint unsigned LOG2_BASE_Q32 = 64'd85605435163;
   localparam longint unsigned LN2_Q32 = 64'd2977044472;
   localparam longint unsigned INV_TWO_PI_Q32 = 64'd683565276;
   localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;

   // quadrant codes from the top two phase bits
   localparam logic [1:0] QUAD_FIRST = 2'd0;
   localparam logic [1:0] QUAD_SECOND = 2'd1;
   localparam logic [1:0] QUAD_THIRD = 2'd2;
   localparam logic [1:0] QUAD_FOURTH = 2'd3;

   // arctangent of 2^-k in Q32 turns
   typedef logic signed [31:0] atan_tab_type [CORDIC_STAGES];
   localparam atan_tab_type ATAN_TURNS = '{
      32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
      32'sd42667331, 32'sd21354465, 32'sd10679838, 32'sd5340245,
      32'sd2670163, 32'sd1335087, 32'sd667544, 32'sd333772,
      32'sd166886, 32'sd83443, 32'sd41722, 32'sd20861
   };

   typedef logic [31:0] theta_tab_type [THETA_ENTRIES];

   // input item as carried by the front stages
   typedef struct packed {
      logic [15:0]        position;
      logic [5:0]         pair_index;
      logic signed [15:0] x_even;
      logic signed [15:0] x_odd;
   } req_item_type;

   // word handed from cell to cell along the rotation chain
   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic [1:0]         quad;
      logic signed [15:0] x_even;
      logic signed [15:0] x_odd;
   } cordic_type;

   // theta of one pair in Q0.32 turns
   function automatic logic [31:0] theta_entry(int unsigned i);
      longint unsigned j;
      longint unsigned k;
      longint unsigned whole;
      longint unsigned f;
      longint unsigned x;
      longint unsigned sum;
      longint unsigned term;
      longint unsigned t;
      j = (64'(i) < PAIRS) ? 64'(i) : PAIRS - 64'd1;
      k = (64'd2 * j * LOG2_BASE_Q32) / DIM_EFF;
      whole = k >> 32;
      f = k & 64'hFFFF_FFFF;
      x = (f * LN2_Q32) >> 32;
      sum = 64'd1 << 32;
      term = 64'd1 << 32;
      // 2^-frac as a truncated series of exp(-frac*ln2)
      term = ((term * x) >> 32) / 64'd1;  sum = sum - term;
      term = ((term * x) >> 32) / 64'd2;  sum = sum + term;
      term = ((term * x) >> 32) / 64'd3;  sum = sum - term;
      term = ((term * x) >> 32) / 64'd4;  sum = sum + term;
      term = ((term * x) >> 32) / 64'd5;  sum = sum - term;
      term = ((term * x) >> 32) / 64'd6;  sum = sum + term;
      term = ((term * x) >> 32) / 64'd7;  sum = sum - term;
      term = ((term * x) >> 32) / 64'd8;  sum = sum + term;
      term = ((term * x) >> 32) / 64'd9;  sum = sum - term;
      term = ((term * x) >> 32) / 64'd10; sum = sum + term;
      term = ((term * x) >> 32) / 64'd11; sum = sum - term;
      term = ((term * x) >> 32) / 64'd12; sum = sum + term;
      term = ((term * x) >> 32) / 64'd13; sum = sum - term;
      term = ((term * x) >> 32) / 64'd14; sum = sum + term;
      term = ((term * x) >> 32) / 64'd15; sum = sum - term;
      term = ((term * x) >> 32) / 64'd16; sum = sum + term;
      term = ((term * x) >> 32) / 64'd17; sum = sum - term;
      term = ((term * x) >> 32) / 64'd18; sum = sum + term;
      term = ((term * x) >> 32) / 64'd19; sum = sum - term;
      term = ((term * x) >> 32) / 64'd20; sum = sum + term;
      t = (sum * INV_TWO_PI_Q32) >> 32;
      t = (whole < 64'd64) ? (t >> whole) : 64'd0;
      return t[31:0];
   endfunction

   // whole theta table, evaluated at elaboration
   function automatic theta_tab_type theta_table_build();
      theta_tab_type tab;
      for (int i = 0; i < THETA_ENTRIES; i++) begin
         tab[i] = theta_entry(i);
      end
      return tab;
   endfunction

endpackage

// File: rtl/rope_if.sv
// rope_if: request and response channel interfaces (valid/ready with payload).
// Depends on nothing.

interface rope_req_if;
   logic               valid;
   logic               ready;
   logic [15:0]        position;
   logic [5:0]         pair_index;
   logic signed [15:0] x_even;
   logic signed [15:0] x_odd;

   modport source (output valid, output position, output pair_index, output x_even,
                   output x_odd, input ready);
   modport sink (input valid, input position, input pair_index, input x_even,
                 input x_odd, output ready);
endinterface

interface rope_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] y_even;
   logic signed [15:0] y_odd;

   modport source (output valid, output y_even, output y_odd, input ready);
   modport sink (input valid, input y_even, input y_odd, output ready);
endinterface

// File: rtl/rope_phase.sv
// rope_phase: theta lookup and phase multiply, two pipeline stages that feed
// the rotation chain. Depends on rope_pkg.

module rope_phase
   import rope_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  req_item_type item_in,
   input  logic         in_valid,
   output logic         in_ready,
   output cordic_type   start_out,
   output logic         out_valid,
   input  logic         out_ready
);

   localparam theta_tab_type THETA_TAB = theta_table_build();

   // lookup stage
   logic               a_valid_ff, a_valid_in;
   logic [15:0]        a_pos_ff;
   logic [31:0]        a_theta_ff;
   logic signed [15:0] a_xe_ff, a_xo_ff;
   logic               a_ready;

   // phase stage
   logic               b_valid_ff, b_valid_in;
   cordic_type         b_data_ff, b_data_in;
   logic               b_ready;
   logic [47:0]        phase_full;

   assign b_ready = !b_valid_ff || out_ready;
   assign a_ready = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   assign a_valid_in = a_ready ? in_valid : a_valid_ff;
   assign b_valid_in = b_ready ? a_valid_ff : b_valid_ff;

   // phase is the low word of position times theta
   assign phase_full = 48'(a_pos_ff) * 48'(a_theta_ff);

   always_comb begin
      b_data_in.x = CORDIC_GAIN_Q30;
      b_data_in.y = '0;
      b_data_in.z = {2'b00, phase_full[29:0]};
      b_data_in.quad = phase_full[31:30];
      b_data_in.x_even = a_xe_ff;
      b_data_in.x_odd = a_xo_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   // payload registers load on a transfer into the stage
   always_ff @(posedge clock) begin
      if (a_ready && in_valid) begin
         a_pos_ff <= item_in.position;
         a_theta_ff <= THETA_TAB[item_in.pair_index];
         a_xe_ff <= item_in.x_even;
         a_xo_ff <= item_in.x_odd;
      end
      if (b_ready && a_valid_ff) begin
         b_data_ff <= b_data_in;
      end
   end

   assign start_out = b_data_ff;
   assign out_valid = b_valid_ff;

endmodule

// File: rtl/rope_cordic_cell.sv
// rope_cordic_cell: one micro-rotation of the CORDIC chain with its own
// pipeline register. Depends on rope_pkg.

module rope_cordic_cell
   import rope_pkg::*;
#(
   parameter int STAGE = 0
)
(
   input  logic       clock,
   input  logic       reset,
   input  cordic_type cell_in,
   input  logic       in_valid,
   output logic       in_ready,
   output cordic_type cell_out,
   output logic       out_valid,
   input  logic       out_ready
);

   logic               valid_ff, valid_in;
   cordic_type         data_ff, data_in;
   logic signed [31:0] dx, dy;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // rotate toward zero residual angle
   assign dx = cell_in.y >>> STAGE;
   assign dy = cell_in.x >>> STAGE;

   always_comb begin
      data_in = cell_in;
      if (!cell_in.z[31]) begin
         data_in.x = cell_in.x - dx;
         data_in.y = cell_in.y + dy;
         data_in.z = cell_in.z - ATAN_TURNS[STAGE];
      end else begin
         data_in.x = cell_in.x + dx;
         data_in.y = cell_in.y - dy;
         data_in.z = cell_in.z + ATAN_TURNS[STAGE];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign cell_out = data_ff;
   assign out_valid = valid_ff;

endmodule

// File: rtl/rope_rotate.sv
// rope_rotate: quadrant fold, pair rotation products, rounding and saturation;
// two stages ending in the output register. Depends on rope_pkg.

module rope_rotate
   import rope_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cordic_type        rot_in,
   input  logic              in_valid,
   output logic              in_ready,
   output logic signed [15:0] y_even,
   output logic signed [15:0] y_odd,
   output logic              out_valid,
   input  logic              out_ready
);

   localparam logic signed [48:0] ROUND_HALF = 49'sd1 <<< 29;
   localparam logic signed [18:0] SAT_MAX = 19'sd32767;
   localparam logic signed [18:0] SAT_MIN = -19'sd32768;

   // product stage
   logic               m_valid_ff, m_valid_in, m_ready;
   logic signed [47:0] m_ec_ff, m_os_ff, m_es_ff, m_oc_ff;
   logic signed [31:0] cos_val, sin_val;

   // output stage
   logic               r_valid_ff, r_valid_in, r_ready;
   logic signed [15:0] r_even_ff, r_odd_ff;
   logic signed [15:0] r_even_in, r_odd_in;
   logic signed [48:0] sum_even, sum_odd;
   logic signed [18:0] q_even, q_odd;

   assign r_ready = !r_valid_ff || out_ready;
   assign m_ready = !m_valid_ff || r_ready;
   assign in_ready = m_ready;

   assign m_valid_in = m_ready ? in_valid : m_valid_ff;
   assign r_valid_in = r_ready ? m_valid_ff : r_valid_ff;

   // map the first-quadrant result onto the full turn
   always_comb begin
      case (rot_in.quad)
         QUAD_FIRST: begin
            cos_val = rot_in.x;
            sin_val = rot_in.y;
         end
         QUAD_SECOND: begin
            cos_val = -rot_in.y;
            sin_val = rot_in.x;
         end
         QUAD_THIRD: begin
            cos_val = -rot_in.x;
            sin_val = -rot_in.y;
         end
         default: begin
            cos_val = rot_in.y;
            sin_val = -rot_in.x;
         end
      endcase
   end

   // Q42 sums, round half up to Q12 by a floor shift
   assign sum_even = 49'(m_ec_ff) - 49'(m_os_ff) + ROUND_HALF;
   assign sum_odd = 49'(m_es_ff) + 49'(m_oc_ff) + ROUND_HALF;
   assign q_even = sum_even[48:30];
   assign q_odd = sum_odd[48:30];

   // clamp to the Q4.12 range
   always_comb begin
      if (q_even > SAT_MAX) begin
         r_even_in = SAT_MAX[15:0];
      end else if (q_even < SAT_MIN) begin
         r_even_in = SAT_MIN[15:0];
      end else begin
         r_even_in = q_even[15:0];
      end
      if (q_odd > SAT_MAX) begin
         r_odd_in = SAT_MAX[15:0];
      end else if (q_odd < SAT_MIN) begin
         r_odd_in = SAT_MIN[15:0];
      end else begin
         r_odd_in = q_odd[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         r_valid_ff <= 1'b0;
      end else begin
         m_valid_ff <= m_valid_in;
         r_valid_ff <= r_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (m_ready && in_valid) begin
         m_ec_ff <= 48'(rot_in.x_even) * 48'(cos_val);
         m_os_ff <= 48'(rot_in.x_odd) * 48'(sin_val);
         m_es_ff <= 48'(rot_in.x_even) * 48'(sin_val);
         m_oc_ff <= 48'(rot_in.x_odd) * 48'(cos_val);
      end
      if (r_ready && m_valid_ff) begin
         r_even_ff <= r_even_in;
         r_odd_ff <= r_odd_in;
      end
   end

   assign y_even = r_even_ff;
   assign y_odd = r_odd_ff;
   assign out_valid = r_valid_ff;

endmodule

// File: rtl/rotary_position_embedding.sv
// rotary_position_embedding: top level of the rotary position embedding block.
// Depends on rope_pkg, rope_if, rope_phase, rope_cordic_cell and rope_rotate.
//
//   channel  dir  handshake        payload
//   req_if   in   valid / ready    position, pair_index, x_even, x_odd
//   rsp_if   out  valid / ready    y_even, y_odd
//
// One transfer per cycle is sustained while results are taken; each item passes
// through 2 phase stages, 16 rotation cells and 2 product/round stages.
// Every stage has its own valid bit and advances when the next one is empty or
// moving, so bubbles close up behind a stalled result and ready falls only
// once all 20 stages hold an item. Synchronous reset clears the valid bits;
// the theta table is constant, so no start-up sequence is needed.

module rotary_position_embedding
   import rope_pkg::*;
(
   input  logic clock,
   input  logic reset,
   rope_req_if.sink   req_if,
   rope_rsp_if.source rsp_if
);

   req_item_type req_item;
   cordic_type   chain_data [CORDIC_STAGES+1];
   logic         chain_valid [CORDIC_STAGES+1];
   logic         chain_ready [CORDIC_STAGES+1];

   assign req_item.position = req_if.position;
   assign req_item.pair_index = req_if.pair_index;
   assign req_item.x_even = req_if.x_even;
   assign req_item.x_odd = req_if.x_odd;

   // theta lookup and phase
   rope_phase u_phase (
      .clock     (clock),
      .reset     (reset),
      .item_in   (req_item),
      .in_valid  (req_if.valid),
      .in_ready  (req_if.ready),
      .start_out (chain_data[0]),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0])
   );

   // chain of micro-rotation cells
   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
      rope_cordic_cell #(
         .STAGE (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_in   (chain_data[g]),
         .in_valid  (chain_valid[g]),
         .in_ready  (chain_ready[g]),
         .cell_out  (chain_data[g+1]),
         .out_valid (chain_valid[g+1]),
         .out_ready (chain_ready[g+1])
      );
   end

   // rotation of the pair and output register
   rope_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .rot_in    (chain_data[CORDIC_STAGES]),
      .in_valid  (chain_valid[CORDIC_STAGES]),
      .in_ready  (chain_ready[CORDIC_STAGES]),
      .y_even    (rsp_if.y_even),
      .y_odd     (rsp_if.y_odd),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready)
   );

   // no result may appear right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_if.valid)
      else $error("result valid after reset");

   // input backpressure only comes from a stalled result
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> (rsp_if.valid && !rsp_if.ready))
      else $error("input stalled without an output stall");

   // residual angle has converged at the end of the chain
   a_residual: assert property (@(posedge clock) disable iff (reset)
      chain_valid[CORDIC_STAGES] |->
         (chain_data[CORDIC_STAGES].z < 32'sd65536 &&
          chain_data[CORDIC_STAGES].z > -32'sd65536))
      else $error("rotation residual out of range");

endmodule
